[hdl/rftt_pkg.sv]
// shared types, constants and helper functions for the rangefinder text block
package rftt_pkg;

    // frame bytes
    localparam logic [7:0] HDR_FIRST  = 8'h10;
    localparam logic [7:0] HDR_SECOND = 8'h01;
    localparam logic [7:0] DESC_VALID = 8'h00;

    // ascii characters
    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_DOT  = 8'h2E;
    localparam logic [7:0] ASCII_FIVE = 8'h35;
    localparam logic [7:0] ASCII_M    = 8'h6D;
    localparam logic [7:0] ASCII_CR   = 8'h0D;
    localparam logic [7:0] ASCII_LF   = 8'h0A;

    // distance limits and fields
    localparam int          METERS_W   = 10;
    localparam logic [14:0] MAX_METERS = 15'd999;
    localparam logic [7:0]  CENTI_HALF = 8'd50;
    localparam logic [7:0]  CENTI_NONE = 8'd0;

    // parser phase
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_HDR2,
        PH_DESC,
        PH_HIGH,
        PH_LOW,
        PH_SUM
    } t_phase;

    // formatter state
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DIG,
        BK_EMIT
    } t_back_state;

    // character slots of one text line
    typedef enum logic [2:0] {
        SL_HUND,
        SL_TENS,
        SL_ONES,
        SL_DOT,
        SL_FRAC,
        SL_UNIT,
        SL_CR,
        SL_LF
    } t_slot;

    // one good frame passed from parser to formatter
    typedef struct packed {
        logic [METERS_W-1:0] meters;
        logic                half;
    } t_dist_rec;

    // meters / 100 for 0..999 by reciprocal multiply (41 / 4096)
    function automatic logic [3:0] f_div100(input logic [METERS_W-1:0] m);
        logic [15:0] p;
        p = 16'(m) * 16'd41;
        return p[15:12];
    endfunction

    // r / 10 for 0..99 by reciprocal multiply (205 / 2048)
    function automatic logic [3:0] f_div10(input logic [6:0] r);
        logic [14:0] p;
        p = 15'(r) * 15'd205;
        return p[14:11];
    endfunction

endpackage

[hdl/rftt_if.sv]
// stream interfaces for received bytes and text characters

interface rftt_rx_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface rftt_txt_if;
    logic        valid;
    logic        ready;
    logic [7:0]  text_char;
    logic        last;
    logic [17:0] packed_distance;
    logic [9:0]  rounded_meters;

    modport source (output valid, output text_char, output last,
                    output packed_distance, output rounded_meters, input ready);
    modport sink   (input valid, input text_char, input last,
                    input packed_distance, input rounded_meters, output ready);
endinterface

[hdl/rftt_front.sv]
// frame parser: hunts headers, checks descriptor, checksum and range, queues good frames
module rftt_front
    import rftt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    rftt_rx_if.sink     i_rx,
    input  logic        i_q_full,
    output logic        o_push,
    output t_dist_rec   o_rec
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_high, r_low;
    logic        rx_xfer;
    logic [7:0]  sum_expect;
    logic [14:0] meters_full;
    logic        frame_good;

    // byte transfer whenever the queue has room
    assign i_rx.ready = !i_q_full;
    assign rx_xfer    = i_rx.valid && i_rx.ready;

    // checksum and range check on the stored high and low bytes
    assign sum_expect  = 8'h00 - (r_high + r_low + 8'd1);
    assign meters_full = {r_high, r_low[7:1]};
    assign frame_good  = (i_rx.rx_byte == sum_expect) && (meters_full <= MAX_METERS);

    assign o_push       = rx_xfer && (r_phase == PH_SUM) && frame_good;
    assign o_rec.meters = meters_full[METERS_W-1:0];
    assign o_rec.half   = r_low[0];

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (rx_xfer) begin
            case (r_phase)
                PH_HUNT: n_phase = (i_rx.rx_byte == HDR_FIRST) ? PH_HDR2 : PH_HUNT;
                PH_HDR2: n_phase = (i_rx.rx_byte == HDR_SECOND) ? PH_DESC : PH_HUNT;
                PH_DESC: n_phase = (i_rx.rx_byte == DESC_VALID) ? PH_HIGH : PH_HUNT;
                PH_HIGH: n_phase = PH_LOW;
                PH_LOW:  n_phase = PH_SUM;
                PH_SUM:  n_phase = PH_HUNT;
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    // phase register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
        end else begin
            r_phase <= n_phase;
        end
    end

    // distance bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_high <= 8'd0;
            r_low  <= 8'd0;
        end else if (rx_xfer && r_phase == PH_HIGH) begin
            r_high <= i_rx.rx_byte;
        end else if (rx_xfer && r_phase == PH_LOW) begin
            r_low <= i_rx.rx_byte;
        end
    end

endmodule

[hdl/rftt_queue.sv]
// small fifo of decoded distances between parser and formatter
module rftt_queue
    import rftt_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_push,
    input  t_dist_rec i_rec,
    output logic      o_full,
    input  logic      i_pop,
    output logic      o_valid,
    output t_dist_rec o_rec
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_dist_rec        r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, r_rd_ptr, n_wr_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_rec   = r_mem[r_rd_ptr];

    // pointer wrap and occupancy
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_rec;
        end
    end

endmodule

[hdl/rftt_back.sv]
// text formatter: splits meters into digits and sends one character per transfer
module rftt_back
    import rftt_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_valid,
    input  t_dist_rec   i_q_rec,
    output logic        o_pop,
    rftt_txt_if.source  o_txt
);

    t_back_state         r_state, n_state;
    t_slot               r_slot, n_slot;
    logic [METERS_W-1:0] r_meters;
    logic                r_half;
    logic [3:0]          r_hund, r_tens, r_ones;
    logic [6:0]          r_rem;
    logic [3:0]          div_hund, div_tens;
    logic [6:0]          div_rem;
    logic [3:0]          dig_ones;
    t_slot               first_slot;
    logic                out_load;
    logic [7:0]          slot_char;

    // output register
    logic        r_out_valid;
    logic [7:0]  r_char;
    logic        r_last;
    logic [17:0] r_packed;
    logic [9:0]  r_rounded;

    assign o_txt.valid           = r_out_valid;
    assign o_txt.text_char       = r_char;
    assign o_txt.last            = r_last;
    assign o_txt.packed_distance = r_packed;
    assign o_txt.rounded_meters  = r_rounded;

    assign o_pop    = (r_state == BK_IDLE) && i_q_valid;
    assign out_load = (r_state == BK_EMIT) && (!r_out_valid || o_txt.ready);

    // hundreds and remainder
    assign div_hund = f_div100(r_meters);
    assign div_rem  = 7'(r_meters - 10'(div_hund) * 10'd100);

    // tens and ones
    assign div_tens = f_div10(r_rem);
    assign dig_ones = 4'(r_rem - 7'(div_tens) * 7'd10);

    // leading zero suppression picks the first slot
    always_comb begin
        if (r_hund != 4'd0) begin
            first_slot = SL_HUND;
        end else if (div_tens != 4'd0) begin
            first_slot = SL_TENS;
        end else if (dig_ones != 4'd0) begin
            first_slot = SL_ONES;
        end else begin
            first_slot = SL_DOT;
        end
    end

    // character of the current slot
    always_comb begin
        case (r_slot)
            SL_HUND: slot_char = ASCII_ZERO + 8'(r_hund);
            SL_TENS: slot_char = ASCII_ZERO + 8'(r_tens);
            SL_ONES: slot_char = ASCII_ZERO + 8'(r_ones);
            SL_DOT:  slot_char = ASCII_DOT;
            SL_FRAC: slot_char = r_half ? ASCII_FIVE : ASCII_ZERO;
            SL_UNIT: slot_char = ASCII_M;
            SL_CR:   slot_char = ASCII_CR;
            SL_LF:   slot_char = ASCII_LF;
            default: slot_char = ASCII_LF;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_slot  = r_slot;
        case (r_state)
            BK_IDLE: begin
                if (i_q_valid) begin
                    n_state = BK_DIV;
                end
            end
            BK_DIV: begin
                n_state = BK_DIG;
            end
            BK_DIG: begin
                n_state = BK_EMIT;
                n_slot  = first_slot;
            end
            BK_EMIT: begin
                if (out_load) begin
                    if (r_slot == SL_LF) begin
                        n_state = BK_IDLE;
                    end else begin
                        n_slot = t_slot'(r_slot + 3'd1);
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
            r_slot  <= SL_HUND;
        end else begin
            r_state <= n_state;
            r_slot  <= n_slot;
        end
    end

    // working registers of the digit split
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_meters <= i_q_rec.meters;
            r_half   <= i_q_rec.half;
        end
        if (r_state == BK_DIV) begin
            r_hund <= div_hund;
            r_rem  <= div_rem;
        end
        if (r_state == BK_DIG) begin
            r_tens <= div_tens;
            r_ones <= dig_ones;
        end
    end

    // output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_txt.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // output payload, distance fields only on the line feed
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_char <= slot_char;
            if (r_slot == SL_LF) begin
                r_last    <= 1'b1;
                r_packed  <= {r_meters, r_half ? CENTI_HALF : CENTI_NONE};
                r_rounded <= r_meters + 10'(r_half);
            end else begin
                r_last    <= 1'b0;
                r_packed  <= 18'd0;
                r_rounded <= 10'd0;
            end
        end
    end

endmodule

[hdl/rangefinder_frame_to_text_top.sv]
// rangefinder frame to text: one received byte per cycle in, ascii distance text out
// input: one byte transfer per cycle while the frame queue has room
// first character path: queue write at the checksum byte transfer, then pop,
// hundreds split, tens split, output register; pop waits while the formatter is busy
// output: one character per cycle while ready, 5 to 8 characters per frame
// reset: synchronous active low, clears parser phase, queue and output valid
module rangefinder_frame_to_text_top
    import rftt_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    rftt_rx_if.sink    i_rx,
    rftt_txt_if.source o_txt
);

    logic      q_full, q_push, q_pop, q_valid;
    t_dist_rec q_in_rec, q_out_rec;

    // front: parse frames
    rftt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rx     (i_rx),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_rec    (q_in_rec)
    );

    // queue between parser and formatter
    rftt_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_rec   (q_in_rec),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_rec   (q_out_rec)
    );

    // back: format text
    rftt_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_rec   (q_out_rec),
        .o_pop     (q_pop),
        .o_txt     (o_txt)
    );

endmodule

[hdl/rftt_checker.sv]
// port checker for the text output of the rangefinder block, with its bind
module rftt_checker
    import rftt_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [7:0]  i_char,
    input logic        i_last,
    input logic [17:0] i_packed,
    input logic [9:0]  i_rounded
);

    // a stalled character holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready |=> i_valid && $stable(i_char) && $stable(i_last))
        else $error("stalled text transfer changed");

    // the end of a line is a line feed
    a_last_lf: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |-> i_char == ASCII_LF)
        else $error("last set on a character other than line feed");

    // distance fields are zero on every other character
    a_zero_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_last |-> i_packed == 18'd0 && i_rounded == 10'd0)
        else $error("distance fields set on a non-final character");

    // rounded meters agree with packed meters and centimeters, centimeters are 0 or 50, meters at most 999
    a_round: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_last |->
            i_rounded == i_packed[17:8] + 10'(i_packed[7:0] == CENTI_HALF)
            && (i_packed[7:0] == CENTI_HALF || i_packed[7:0] == CENTI_NONE)
            && i_packed[17:8] <= 10'd999)
        else $error("packed and rounded distance disagree");

endmodule

bind rangefinder_frame_to_text_top rftt_checker u_rftt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .i_valid   (o_txt.valid),
    .i_ready   (o_txt.ready),
    .i_char    (o_txt.text_char),
    .i_last    (o_txt.last),
    .i_packed  (o_txt.packed_distance),
    .i_rounded (o_txt.rounded_meters)
);
